// ===== hdl/sha_eng_pkg.sv =====
// Shared types, initial hash value and round constant table of the SHA-256 engine.
`timescale 1ns / 1ps

package sha_eng_pkg;

	typedef logic [31:0] word_t;
	typedef word_t [0:7] vars_t;

	localparam int unsigned BLK_BITS = 512;
	localparam logic [5:0]  RND_LAST = 6'd63;
	localparam logic [5:0]  POS_LAST = 6'd63;
	localparam logic [5:0]  POS_LEN  = 6'd56;
	localparam logic [2:0]  IDX_LAST = 3'd7;
	localparam logic [7:0]  PAD_BYTE = 8'h80;

	localparam vars_t HASH_IV = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic word_t round_k(input logic [5:0] t);
		word_t k;
		case (t)
			6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

endpackage

// ===== hdl/sha256_hash_engine_core.sv =====
// Top level of the SHA-256 engine: byte packing, padding sequencer, round loop, digest out.
// Each message byte is taken in IDLE; the byte that fills a block starts 64 rounds, then the fold.
// End transaction: 9 to 72 padding bytes plus one or two compressions,
// then 8 digest transactions at one per cycle when m_tready stays high.
// s_tready is low outside IDLE, so no bytes enter while the single shared round unit runs.
// Reset: arst_n clears the sequencer, the counters and loads the initial hash at once.
`timescale 1ns / 1ps

module sha256_hash_engine_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] byte_present
	input  logic        s_tlast,   // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
	output logic        m_tlast    // last_word
);
	import sha_eng_pkg::*;

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PAD   = 3'd1;
	localparam logic [2:0] ST_ROUND = 3'd2;
	localparam logic [2:0] ST_FINAL = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	// padding phases: before the 0x80 byte, zero fill, length bytes
	localparam logic [1:0] PH_MSG  = 2'd0;
	localparam logic [1:0] PH_ZERO = 2'd1;
	localparam logic [1:0] PH_LEN  = 2'd2;

	logic [2:0]           state_q;
	logic [1:0]           phase_q;
	logic                 pad_q;       // end transaction taken, digest pending
	logic [5:0]           pos_q;       // byte position inside the block
	logic [5:0]           round_q;
	logic [2:0]           out_idx_q;
	logic [63:0]          bit_count_q;
	vars_t                hash_q;
	vars_t                v_q;
	logic [BLK_BITS-1:0]  win_q;       // block bytes, then the 16-word schedule window

	logic       s_acc;
	logic       byte_shift;
	logic [7:0] byte_val;
	logic [7:0] pad_val;
	logic       len_shift;
	logic       blk_full;
	vars_t      v_next;
	word_t      w_new;

	// Handshake and byte path control
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;

	always_comb begin
		case (phase_q)
			PH_MSG:  pad_val = PAD_BYTE;
			PH_ZERO: pad_val = (pos_q == POS_LEN) ? bit_count_q[63:56] : 8'h00;
			PH_LEN:  pad_val = bit_count_q[63:56];
			default: pad_val = 8'h00;
		endcase
	end

	// The length goes out MSB first by shifting the count; it is zero afterward.
	assign len_shift  = (state_q == ST_PAD) &&
		((phase_q == PH_LEN) || ((phase_q == PH_ZERO) && (pos_q == POS_LEN)));
	assign byte_shift = (s_acc && s_tuser) || (state_q == ST_PAD);
	assign byte_val   = (state_q == ST_PAD) ? pad_val : s_tdata;
	assign blk_full   = byte_shift && (pos_q == POS_LAST);

	// Shared round unit: the window always presents W[t] at word 0.
	sha_eng_round u_round (
		.v      (v_q),
		.w0     (win_q[511:480]),
		.w1     (win_q[479:448]),
		.w9     (win_q[223:192]),
		.w14    (win_q[63:32]),
		.k      (round_k(round_q)),
		.v_next (v_next),
		.w_new  (w_new)
	);

	// Datapath registers: bytes shift in from the low end, rounds shift words out the top.
	always_ff @(posedge clk) begin
		if (byte_shift) begin
			win_q <= {win_q[BLK_BITS-9:0], byte_val};
		end else if (state_q == ST_ROUND) begin
			win_q <= {win_q[BLK_BITS-33:0], w_new};
		end
	end

	always_ff @(posedge clk) begin
		if (blk_full) begin
			v_q <= hash_q;
		end else if (state_q == ST_ROUND) begin
			v_q <= v_next;
		end
	end

	// Sequencer, counters and chaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_MSG;
			pad_q       <= 1'b0;
			pos_q       <= 6'd0;
			round_q     <= 6'd0;
			out_idx_q   <= 3'd0;
			bit_count_q <= 64'd0;
			hash_q      <= HASH_IV;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						if (s_tuser) begin
							pos_q       <= pos_q + 6'd1;
							bit_count_q <= bit_count_q + 64'd8;
						end
						if (s_tlast) begin
							pad_q <= 1'b1;
						end
						if (blk_full) begin
							round_q <= 6'd0;
							state_q <= ST_ROUND;
						end else if (s_tlast) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					pos_q <= pos_q + 6'd1;
					if (len_shift) begin
						bit_count_q <= {bit_count_q[55:0], 8'h00};
					end
					if (phase_q == PH_MSG) begin
						phase_q <= PH_ZERO;
					end else if (len_shift) begin
						phase_q <= PH_LEN;
					end
					if (blk_full) begin
						round_q <= 6'd0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == RND_LAST) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					for (int i = 0; i < 8; i++) begin
						hash_q[i] <= hash_q[i] + v_q[i];
					end
					if (!pad_q) begin
						state_q <= ST_IDLE;
					end else if (phase_q == PH_LEN) begin
						out_idx_q <= 3'd0;
						state_q   <= ST_OUT;
					end else begin
						state_q <= ST_PAD;
					end
				end
				ST_OUT: begin
					if (m_tready) begin
						out_idx_q <= out_idx_q + 3'd1;
						if (out_idx_q == IDX_LAST) begin
							hash_q  <= HASH_IV;
							phase_q <= PH_MSG;
							pad_q   <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Digest output: words straight from the chaining registers
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {5'b00000, out_idx_q, hash_q[out_idx_q]};
	assign m_tlast  = (out_idx_q == IDX_LAST);

	// Checks
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input and output sides active together");

	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && round_q == RND_LAST) |=> (state_q == ST_FINAL))
		else $error("round loop did not end after the last round");

	a_digest_clean: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> (pos_q == 6'd0 && bit_count_q == 64'd0 && out_idx_q == 3'd0))
		else $error("digest started with padding unfinished");

	a_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (s_tready && hash_q == HASH_IV))
		else $error("engine not restarted after last digest word");

endmodule

// ===== hdl/sha_eng_round.sv =====
// One SHA-256 compression round plus the next message schedule word.
`timescale 1ns / 1ps

module sha_eng_round (
	input  sha_eng_pkg::vars_t v,
	input  sha_eng_pkg::word_t w0,
	input  sha_eng_pkg::word_t w1,
	input  sha_eng_pkg::word_t w9,
	input  sha_eng_pkg::word_t w14,
	input  sha_eng_pkg::word_t k,
	output sha_eng_pkg::vars_t v_next,
	output sha_eng_pkg::word_t w_new
);
	import sha_eng_pkg::*;

	function automatic word_t big_s0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_s1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t small_s0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t small_s1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

	word_t t1;
	word_t t2;
	word_t ch;
	word_t maj;

	always_comb begin
		ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
		maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
		t1  = v[7] + big_s1(v[4]) + ch + k + w0;
		t2  = big_s0(v[0]) + maj;
		v_next = '{t1 + t2, v[0], v[1], v[2], v[3] + t1, v[4], v[5], v[6]};
		w_new  = small_s1(w14) + w9 + small_s0(w1) + w0;
	end

endmodule
